// File: rtl/core/stpr_pkg.sv
// package of the stepper trapezoid ramp block: sizes, codes, control types
package stpr_pkg;

	localparam int LEVELS  = 32;
	localparam int LVL_W   = $clog2(LEVELS);
	localparam int MAX_RST = (LEVELS - 1 < 19) ? LEVELS - 1 : 19;

	localparam int KIND_W = 2;
	localparam int IDX_W  = 5;
	localparam int VAL_W  = 16;
	localparam int POS_W  = 32;

	localparam logic [VAL_W-1:0] VAL_MAX = 16'hFFFF;

	typedef enum logic [KIND_W-1:0] {
		K_LOAD = 2'd0,
		K_MOVE = 2'd1,
		K_TICK = 2'd2,
		K_STOP = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		PH_IDLE   = 3'd0,
		PH_UP     = 3'd1,
		PH_CRUISE = 3'd2,
		PH_DOWN   = 3'd3,
		PH_LAST   = 3'd4
	} phase_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_MV_CHK,
		S_MV_SUM,
		S_MV_FIN,
		S_TK_CHK,
		S_TK_A,
		S_TK_B,
		S_TK_P,
		S_TK_E,
		S_STOP,
		S_DONE
	} state_t;

	typedef enum logic [2:0] {
		RD_ZERO,
		RD_NEXT_K,
		RD_TK_A,
		RD_TK_B,
		RD_LVL
	} rd_sel_t;

	typedef struct packed {
		logic [VAL_W-1:0] period;
		logic [VAL_W-1:0] steps;
	} entry_t;

	typedef struct packed {
		rd_sel_t rd_sel;
		logic    take;
		logic    load_wr;
		logic    mv_chk;
		logic    sum_step;
		logic    mv_fin;
		logic    tk_chk;
		logic    tk_lat_a;
		logic    tk_lvl;
		logic    tk_fin;
		logic    stop_do;
		logic    out_load;
	} cmd_t;

	typedef struct packed {
		logic move_ok;
		logic k_last;
		logic active;
		logic out_free;
	} status_t;

endpackage

// File: rtl/core/stpr_req_if.sv
// request channel of the stepper ramp block
interface stpr_req_if;
	logic                             valid;
	logic                             ready;
	logic [stpr_pkg::KIND_W-1:0]      kind;
	logic [stpr_pkg::IDX_W-1:0]       entry_index;
	logic [stpr_pkg::VAL_W-1:0]       entry_period;
	logic [stpr_pkg::VAL_W-1:0]       entry_steps;
	logic signed [stpr_pkg::POS_W-1:0] target_position;
	logic [stpr_pkg::IDX_W-1:0]       top_level;

	modport source (
		output valid, kind, entry_index, entry_period, entry_steps, target_position, top_level,
		input  ready
	);
	modport sink (
		input  valid, kind, entry_index, entry_period, entry_steps, target_position, top_level,
		output ready
	);
endinterface

// File: rtl/core/stpr_rsp_if.sv
// result channel of the stepper ramp block
interface stpr_rsp_if;
	logic                              valid;
	logic                              ready;
	logic                              step_level;
	logic                              direction;
	logic                              driver_enabled;
	logic [stpr_pkg::VAL_W-1:0]        half_period;
	logic                              running;
	logic signed [stpr_pkg::POS_W-1:0] position;

	modport source (
		output valid, step_level, direction, driver_enabled, half_period, running, position,
		input  ready
	);
	modport sink (
		input  valid, step_level, direction, driver_enabled, half_period, running, position,
		output ready
	);
endinterface

// File: rtl/core/stpr_ctrl.sv
// sequencer of the stepper ramp block: request decode and per-request step order
module stpr_ctrl (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	input  logic [stpr_pkg::KIND_W-1:0] in_kind,
	input  stpr_pkg::status_t           st,
	output logic                        in_ready,
	output stpr_pkg::cmd_t              cmd
);

	stpr_pkg::state_t state_q;
	stpr_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= stpr_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			stpr_pkg::S_IDLE: begin
				if (in_valid) begin
					unique case (stpr_pkg::kind_t'(in_kind))
						stpr_pkg::K_LOAD: state_d = stpr_pkg::S_IDLE;
						stpr_pkg::K_MOVE: state_d = stpr_pkg::S_MV_CHK;
						stpr_pkg::K_TICK: state_d = stpr_pkg::S_TK_CHK;
						stpr_pkg::K_STOP: state_d = stpr_pkg::S_STOP;
					endcase
				end
			end
			stpr_pkg::S_MV_CHK: state_d = st.move_ok ? stpr_pkg::S_MV_SUM : stpr_pkg::S_DONE;
			stpr_pkg::S_MV_SUM: state_d = st.k_last ? stpr_pkg::S_MV_FIN : stpr_pkg::S_MV_SUM;
			stpr_pkg::S_MV_FIN: state_d = stpr_pkg::S_DONE;
			stpr_pkg::S_TK_CHK: state_d = st.active ? stpr_pkg::S_TK_A : stpr_pkg::S_DONE;
			stpr_pkg::S_TK_A:   state_d = stpr_pkg::S_TK_B;
			stpr_pkg::S_TK_B:   state_d = stpr_pkg::S_TK_P;
			stpr_pkg::S_TK_P:   state_d = stpr_pkg::S_TK_E;
			stpr_pkg::S_TK_E:   state_d = stpr_pkg::S_DONE;
			stpr_pkg::S_STOP:   state_d = stpr_pkg::S_DONE;
			stpr_pkg::S_DONE:   state_d = st.out_free ? stpr_pkg::S_IDLE : stpr_pkg::S_DONE;
			default:            state_d = stpr_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		cmd.rd_sel = stpr_pkg::RD_ZERO;
		in_ready = 1'b0;
		unique case (state_q)
			stpr_pkg::S_IDLE: begin
				in_ready    = 1'b1;
				cmd.take    = in_valid;
				cmd.load_wr = in_valid && (stpr_pkg::kind_t'(in_kind) == stpr_pkg::K_LOAD);
			end
			stpr_pkg::S_MV_CHK: begin
				cmd.mv_chk = 1'b1;
				cmd.rd_sel = stpr_pkg::RD_ZERO;
			end
			stpr_pkg::S_MV_SUM: begin
				cmd.sum_step = 1'b1;
				cmd.rd_sel   = stpr_pkg::RD_NEXT_K;
			end
			stpr_pkg::S_MV_FIN: cmd.mv_fin = 1'b1;
			stpr_pkg::S_TK_CHK: begin
				cmd.tk_chk = 1'b1;
				cmd.rd_sel = stpr_pkg::RD_TK_A;
			end
			stpr_pkg::S_TK_A: begin
				cmd.tk_lat_a = 1'b1;
				cmd.rd_sel   = stpr_pkg::RD_TK_B;
			end
			stpr_pkg::S_TK_B:   cmd.tk_lvl = 1'b1;
			stpr_pkg::S_TK_P:   cmd.rd_sel = stpr_pkg::RD_LVL;
			stpr_pkg::S_TK_E:   cmd.tk_fin = 1'b1;
			stpr_pkg::S_STOP:   cmd.stop_do = 1'b1;
			stpr_pkg::S_DONE:   cmd.out_load = st.out_free;
			default: begin
			end
		endcase
	end

endmodule

// File: rtl/core/stpr_dp.sv
// datapath of the stepper ramp block: level table, ramp counters, position, result register
module stpr_dp (
	input  logic                              clk,
	input  logic                              arst_n,
	input  stpr_pkg::cmd_t                    cmd,
	output stpr_pkg::status_t                 st,
	input  logic [stpr_pkg::IDX_W-1:0]        entry_index,
	input  logic [stpr_pkg::VAL_W-1:0]        entry_period,
	input  logic [stpr_pkg::VAL_W-1:0]        entry_steps,
	input  logic signed [stpr_pkg::POS_W-1:0] target_position,
	input  logic [stpr_pkg::IDX_W-1:0]        top_level,
	input  logic                              out_ready,
	output logic                              out_valid,
	output logic                              step_level,
	output logic                              direction,
	output logic                              driver_enabled,
	output logic [stpr_pkg::VAL_W-1:0]        half_period,
	output logic                              running,
	output logic signed [stpr_pkg::POS_W-1:0] position
);

	localparam int LW = stpr_pkg::LVL_W;
	localparam int VW = stpr_pkg::VAL_W;
	localparam int PW = stpr_pkg::POS_W;

	stpr_pkg::entry_t mem [stpr_pkg::LEVELS];
	stpr_pkg::entry_t rd_q;
	logic [LW-1:0]    rd_addr;
	logic [LW-1:0]    wr_addr;
	logic             idx_ok;

	logic signed [PW-1:0] tgt_q;
	logic [stpr_pkg::IDX_W-1:0] top_q;

	logic signed [PW-1:0] pos_q;
	logic                 sign_q;
	stpr_pkg::phase_t     phase_q;
	logic [VW-1:0]        sc_q;
	logic [VW-1:0]        ml_q;
	logic [VW-1:0]        mid_q;
	logic [VW-1:0]        ds_q;
	logic                 cruise_q;
	logic [PW-1:0]        nc_q;
	logic [LW-1:0]        lvl_q;
	logic [LW-1:0]        max_q;
	logic                 half_q;
	logic                 pin_q;
	logic [VW-1:0]        hp_q;
	logic [VW-1:0]        sum_q;
	logic [LW-1:0]        k_q;
	logic [VW-1:0]        a_q;
	logic                 out_valid_q;

	logic                 accel;
	logic                 busy;
	logic                 k_last;
	logic signed [PW:0]   diff;
	logic [PW:0]          span;
	logic [VW-1:0]        ml_new;
	logic [LW-1:0]        max_new;
	logic [VW:0]          sum_add;
	logic [VW:0]          two_sum;
	logic                 cruise_new;
	logic [VW-1:0]        mid_tri;
	logic [VW:0]          edge_cnt;
	logic [PW-1:0]        sc_ext;
	stpr_pkg::phase_t     phase_new;

	assign accel  = (phase_q == stpr_pkg::PH_UP) || (phase_q == stpr_pkg::PH_CRUISE);
	assign busy   = (phase_q != stpr_pkg::PH_IDLE);
	assign k_last = (k_q == max_q);
	assign sc_ext = PW'(sc_q);

	assign st.move_ok  = !busy && (pos_q != tgt_q);
	assign st.k_last   = k_last;
	assign st.active   = accel || (phase_q == stpr_pkg::PH_DOWN);
	assign st.out_free = !out_valid_q || out_ready;

	assign idx_ok  = (32'(entry_index) < stpr_pkg::LEVELS);
	assign wr_addr = LW'(entry_index);

	always_comb begin
		rd_addr = '0;
		unique case (cmd.rd_sel)
			stpr_pkg::RD_ZERO:   rd_addr = '0;
			stpr_pkg::RD_NEXT_K: rd_addr = k_last ? k_q : k_q + LW'(1);
			stpr_pkg::RD_TK_A: begin
				if (accel) begin
					if (lvl_q == '0 || lvl_q >= max_q) rd_addr = (lvl_q == '0) ? '0 : lvl_q;
					else rd_addr = lvl_q + LW'(1);
				end else begin
					if (lvl_q == max_q || lvl_q == '0) rd_addr = lvl_q;
					else rd_addr = lvl_q - LW'(1);
				end
			end
			stpr_pkg::RD_TK_B: begin
				if (accel) rd_addr = LW'(1);
				else rd_addr = (lvl_q == '0) ? '0 : lvl_q - LW'(1);
			end
			stpr_pkg::RD_LVL:    rd_addr = lvl_q;
			default:             rd_addr = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.load_wr && idx_ok) begin
			mem[wr_addr] <= '{period: entry_period, steps: entry_steps};
		end
		rd_q <= mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			tgt_q <= target_position;
			top_q <= top_level;
		end
	end

	// distance, direction and clamped top level of a new move, plus the sums for the ramp plan and tick edges
	always_comb begin
		diff = $signed({tgt_q[PW-1], tgt_q}) - $signed({pos_q[PW-1], pos_q});
		span = diff[PW] ? -diff : diff;
		ml_new = (span > (PW+1)'(stpr_pkg::VAL_MAX)) ? stpr_pkg::VAL_MAX : span[VW-1:0];
		if (32'(top_q) > stpr_pkg::LEVELS - 1) max_new = LW'(stpr_pkg::LEVELS - 1);
		else max_new = LW'(top_q);
		sum_add    = {1'b0, sum_q} + {1'b0, rd_q.steps};
		two_sum    = {sum_q, 1'b0};
		cruise_new = ({1'b0, ml_q} > two_sum);
		mid_tri    = (ml_q - VW'(1)) >> 1;
		edge_cnt   = {1'b0, ds_q} + {1'b0, a_q};
	end

	always_comb begin
		phase_new = phase_q;
		unique case (phase_q)
			stpr_pkg::PH_UP: begin
				if (sc_q == mid_q) phase_new = cruise_q ? stpr_pkg::PH_CRUISE : stpr_pkg::PH_DOWN;
			end
			stpr_pkg::PH_CRUISE: begin
				if (sc_q == ds_q) phase_new = stpr_pkg::PH_DOWN;
			end
			stpr_pkg::PH_DOWN: begin
				if (sc_q == ml_q) phase_new = stpr_pkg::PH_LAST;
			end
			default: phase_new = phase_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			sign_q   <= 1'b0;
			phase_q  <= stpr_pkg::PH_IDLE;
			sc_q     <= '0;
			ml_q     <= '0;
			mid_q    <= '0;
			ds_q     <= '0;
			cruise_q <= 1'b0;
			nc_q     <= '0;
			lvl_q    <= '0;
			max_q    <= LW'(stpr_pkg::MAX_RST);
			half_q   <= 1'b0;
			pin_q    <= 1'b1;
			hp_q     <= '0;
			sum_q    <= '0;
			k_q      <= '0;
			a_q      <= '0;
		end else begin
			if (cmd.mv_chk && st.move_ok) begin
				sign_q <= !diff[PW];
				ml_q   <= ml_new;
				max_q  <= max_new;
				sum_q  <= '0;
				k_q    <= '0;
			end
			if (cmd.sum_step) begin
				sum_q <= sum_add[VW] ? stpr_pkg::VAL_MAX : sum_add[VW-1:0];
				if (k_q == '0) hp_q <= rd_q.period;
				if (!k_last) k_q <= k_q + LW'(1);
			end
			if (cmd.mv_fin) begin
				cruise_q <= cruise_new;
				mid_q    <= cruise_new ? sum_q : mid_tri;
				ds_q     <= cruise_new ? ml_q - sum_q : mid_tri;
				sc_q     <= '0;
				nc_q     <= '0;
				lvl_q    <= '0;
				phase_q  <= stpr_pkg::PH_UP;
			end
			if (cmd.tk_chk && !st.active) begin
				phase_q <= stpr_pkg::PH_IDLE;
			end
			if (cmd.tk_lat_a) begin
				a_q <= rd_q.steps;
			end
			if (cmd.tk_lvl) begin
				if (accel) begin
					if (lvl_q >= max_q) begin
					end else if (lvl_q == '0) begin
						if (sc_q == a_q) begin
							nc_q  <= nc_q + PW'(a_q) + PW'(rd_q.steps);
							lvl_q <= LW'(1);
						end
					end else if (sc_ext == nc_q) begin
						lvl_q <= lvl_q + LW'(1);
						nc_q  <= nc_q + PW'(a_q);
					end
				end else begin
					if (lvl_q == '0) begin
					end else if (lvl_q == max_q) begin
						if ({1'b0, sc_q} == edge_cnt) begin
							nc_q  <= PW'(edge_cnt) + PW'(rd_q.steps);
							lvl_q <= lvl_q - LW'(1);
						end
					end else if (sc_ext == nc_q) begin
						lvl_q <= lvl_q - LW'(1);
						nc_q  <= nc_q + PW'(a_q);
					end
				end
			end
			if (cmd.tk_fin) begin
				hp_q    <= rd_q.period;
				phase_q <= phase_new;
				pin_q   <= !pin_q;
				half_q  <= !half_q;
				// position and step count advance on every other pin edge, when half_q is low
				if (phase_new != stpr_pkg::PH_LAST && !half_q) begin
					pos_q <= sign_q ? pos_q + PW'(1) : pos_q - PW'(1);
					sc_q  <= sc_q + VW'(1);
				end
			end
			if (cmd.stop_do && accel) begin
				sc_q    <= ds_q;
				phase_q <= stpr_pkg::PH_DOWN;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			step_level     <= pin_q;
			direction      <= sign_q;
			driver_enabled <= busy;
			half_period    <= hp_q;
			running        <= busy;
			position       <= pos_q;
		end
	end

	assign out_valid = out_valid_q;

endmodule

// File: rtl/core/stepper_trapezoid_ramp_top.sv
// top level of the stepper trapezoid ramp generator
//
// req carries one request per handshake (valid and ready high at a rising edge):
// a table load, a move start, a timer tick or a stop. rsp carries one result
// for every move, tick and stop; table loads give none.
// a load is written to the table as it is taken and the next request can follow at once.
// a move sums the step counts of levels 0 to its top level through the single
// read port of the level table, one entry per cycle. a tick during a ramp
// makes three serial table reads before its result is ready.
// results land in an output register; the block takes the next request while
// a result waits there and stalls only if a second result is ready before the
// first is taken, so a stalled receiver drops nothing.
// after reset the position is zero, no move runs, the step pin is high and the
// level table holds no valid entries until loaded.
module stepper_trapezoid_ramp_top (
	input logic        clk,
	input logic        arst_n,
	stpr_req_if.sink   req,
	stpr_rsp_if.source rsp
);

	stpr_pkg::cmd_t    cmd;
	stpr_pkg::status_t st;

	stpr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_kind  (req.kind),
		.st       (st),
		.in_ready (req.ready),
		.cmd      (cmd)
	);

	stpr_dp u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.st              (st),
		.entry_index     (req.entry_index),
		.entry_period    (req.entry_period),
		.entry_steps     (req.entry_steps),
		.target_position (req.target_position),
		.top_level       (req.top_level),
		.out_ready       (rsp.ready),
		.out_valid       (rsp.valid),
		.step_level      (rsp.step_level),
		.direction       (rsp.direction),
		.driver_enabled  (rsp.driver_enabled),
		.half_period     (rsp.half_period),
		.running         (rsp.running),
		.position        (rsp.position)
	);

endmodule
